// File: src/lpmd_pkg.sv
`timescale 1ns / 1ps

package lpmd_pkg;

  localparam logic [31:0] SIZE_FIELD_BYTES = 32'd4;
  localparam logic [31:0] MIN_MESSAGE_SIZE = 32'd7;
  localparam logic [31:0] MAX_SIZE_RESET   = 32'd8192;
  localparam int          SIZE_LOW_BYTES   = 3;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  typedef enum logic [1:0] {
    PH_SIZE = 2'd0,
    PH_BODY = 2'd1,
    PH_DROP = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_HEADER   = 2'd0,
    ST_BODY     = 2'd1,
    ST_BAD_SIZE = 2'd2,
    ST_ABORT    = 2'd3
  } status_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       segment_end;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  out_byte;
    logic        message_last;
    logic [31:0] message_length;
  } result_t;

endpackage

// File: src/lpmd_in_stage.sv
`timescale 1ns / 1ps

module lpmd_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpmd_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              item_valid,
  output lpmd_pkg::in_item_t item
);
  import lpmd_pkg::*;

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// File: src/lpmd_engine.sv
`timescale 1ns / 1ps

module lpmd_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic               advance,
  input  lpmd_pkg::in_item_t item,
  output logic               result_valid,
  output lpmd_pkg::result_t  result
);
  import lpmd_pkg::*;

  logic [31:0] max_size;
  phase_t      phase;
  phase_t      phase_next;
  logic [31:0] byte_count;
  logic [31:0] byte_count_next;
  logic [31:0] expected_length;
  logic [31:0] expected_length_next;
  logic [7:0]  size_bytes [SIZE_LOW_BYTES];

  logic [31:0] count_inc;
  logic [31:0] size_word;
  logic        size_bad;
  logic        size_partial;
  logic        body_done;

  assign count_inc    = byte_count + 32'd1;
  assign size_word    = {item.data_byte, size_bytes[2], size_bytes[1], size_bytes[0]};
  assign size_bad     = (size_word < MIN_MESSAGE_SIZE) || (size_word > max_size);
  assign size_partial = byte_count < (SIZE_FIELD_BYTES - 32'd1);
  assign body_done    = count_inc >= expected_length;

  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    expected_length_next = expected_length;
    if (item.kind == KIND_RESET) begin
      phase_next           = PH_SIZE;
      byte_count_next      = 32'd0;
      expected_length_next = 32'd0;
    end else begin
      unique case (phase)
        PH_DROP: begin
          if (item.segment_end) begin
            phase_next = PH_SIZE;
          end
        end
        PH_BODY: begin
          if (body_done) begin
            phase_next           = PH_SIZE;
            byte_count_next      = 32'd0;
            expected_length_next = 32'd0;
          end else begin
            byte_count_next = count_inc;
          end
        end
        default: begin
          phase_next = PH_SIZE;
          if (size_partial) begin
            byte_count_next = count_inc;
          end else begin
            expected_length_next = size_word;
            if (size_bad) begin
              byte_count_next = 32'd0;
              phase_next      = item.segment_end ? PH_SIZE : PH_DROP;
            end else begin
              byte_count_next = SIZE_FIELD_BYTES;
              phase_next      = PH_BODY;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    result_valid = 1'b0;
    result       = '{status: ST_BODY, out_byte: 8'd0, message_last: 1'b0,
                     message_length: expected_length};
    if (item.kind == KIND_RESET) begin
      if (phase == PH_BODY) begin
        result_valid  = 1'b1;
        result.status = ST_ABORT;
      end
    end else begin
      unique case (phase)
        PH_DROP: begin
          result_valid = 1'b0;
        end
        PH_BODY: begin
          result_valid        = 1'b1;
          result.out_byte     = item.data_byte;
          result.message_last = body_done;
        end
        default: begin
          if (!size_partial) begin
            result_valid          = 1'b1;
            result.message_length = size_word;
            result.status         = size_bad ? ST_BAD_SIZE : ST_HEADER;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size <= MAX_SIZE_RESET;
    end else if (cfg_we) begin
      max_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE;
      byte_count      <= 32'd0;
      expected_length <= 32'd0;
    end else if (advance) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      expected_length <= expected_length_next;
    end
  end

  // capture low size bytes while the size field is still partial
  always_ff @(posedge clk) begin
    if (advance && item.kind == KIND_DATA && phase != PH_BODY && phase != PH_DROP
        && size_partial) begin
      size_bytes[byte_count[1:0]] <= item.data_byte;
    end
  end

endmodule

// File: src/lpmd_out_stage.sv
`timescale 1ns / 1ps

module lpmd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  lpmd_pkg::result_t result,
  input  logic              out_ready,
  output logic              out_valid,
  output lpmd_pkg::result_t out_result
);
  import lpmd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= result;
    end
  end

endmodule

// File: src/length_prefixed_message_deframer_core.sv
`timescale 1ns / 1ps
// Channel  | Direction | tdata                        | tuser      | tlast
// s_axis   | in        | data_byte                    | kind       | segment_end
// m_axis   | out       | out_byte, message_length     | status     | message_last
// cfg      | in        | cfg_wdata = max_message_size (cfg_we strobe)
//
// One request per cycle unless m_axis stalls. Requests are registered in the input
// stage, results in the output stage, with a single size/body counter in between.
// rst clears phase, counters and both stage valids; max_message_size returns to 8192.
// A stalled m_axis holds its result; s_axis keeps accepting while the input
// stage can hand its request to the engine.

module length_prefixed_message_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] kind
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [7:0] out_byte, [39:8] message_length
  output logic [1:0]  m_axis_tuser,  // [1:0] status
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import lpmd_pkg::*;

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     advance;
  logic     result_valid;
  result_t  result;
  result_t  out_result;

  assign in_item = '{kind: s_axis_tuser, data_byte: s_axis_tdata,
                     segment_end: s_axis_tlast};
  assign advance = item_valid && (!m_axis_tvalid || m_axis_tready);

  lpmd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  lpmd_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .advance      (advance),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
  );

  lpmd_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && result_valid),
    .result     (result),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_result (out_result)
  );

  assign m_axis_tdata = {out_result.message_length, out_result.out_byte};
  assign m_axis_tuser = out_result.status;
  assign m_axis_tlast = out_result.message_last;

endmodule

// File: verif/tb_length_prefixed_message_deframer_core.sv
`timescale 1ns / 1ps

module tb_length_prefixed_message_deframer_core;
  import lpmd_pkg::*;

  class deframer_scoreboard;
    phase_t      phase;
    logic [31:0] byte_count;
    logic [31:0] expected_length;
    logic [31:0] max_size;
    logic [7:0]  size_lo[3];
    result_t     pending_results[$];
    int unsigned errors;

    function new();
      phase           = PH_SIZE;
      byte_count      = '0;
      expected_length = '0;
      max_size        = MAX_SIZE_RESET;
      errors          = 0;
    endfunction

    function void clear_channel();
      phase           = PH_SIZE;
      byte_count      = '0;
      expected_length = '0;
    endfunction

    function void note_request(in_item_t req);
      result_t     r;
      logic [31:0] size;
      bit          has_result;
      r          = '0;
      has_result = 1'b0;
      if (req.kind == KIND_RESET) begin
        if (phase == PH_BODY) begin
          r.status         = ST_ABORT;
          r.message_length = expected_length;
          has_result       = 1'b1;
        end
        clear_channel();
      end else if (phase == PH_DROP) begin
        if (req.segment_end) phase = PH_SIZE;
      end else if (phase == PH_BODY) begin
        byte_count       = byte_count + 32'd1;
        r.status         = ST_BODY;
        r.out_byte       = req.data_byte;
        r.message_length = expected_length;
        has_result       = 1'b1;
        if (byte_count >= expected_length) begin
          r.message_last = 1'b1;
          clear_channel();
        end
      end else begin
        phase = PH_SIZE;
        if (byte_count < SIZE_FIELD_BYTES - 32'd1) begin
          size_lo[byte_count[1:0]] = req.data_byte;
          byte_count = byte_count + 32'd1;
        end else begin
          size             = {req.data_byte, size_lo[2], size_lo[1], size_lo[0]};
          expected_length  = size;
          r.message_length = size;
          has_result       = 1'b1;
          if (size < MIN_MESSAGE_SIZE || size > max_size) begin
            byte_count = '0;
            phase      = req.segment_end ? PH_SIZE : PH_DROP;
            r.status   = ST_BAD_SIZE;
          end else begin
            byte_count = SIZE_FIELD_BYTES;
            phase      = PH_BODY;
            r.status   = ST_HEADER;
          end
        end
      end
      if (has_result) pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d, length %0d", got.status, got.message_length);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.message_last !== want.message_last) begin
        $error("message_last: expected %0d, actual %0d", want.message_last, got.message_last);
        errors++;
      end
      if (got.message_length !== want.message_length) begin
        $error("message_length: expected %0d, actual %0d",
               want.message_length, got.message_length);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  deframer_scoreboard sb = new();
  bit tx_gaps_on  = 1'b1;
  bit rx_gaps_on  = 1'b1;
  bit rx_hold_req = 1'b0;
  int sent_items  = 0;

  length_prefixed_message_deframer_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always #10 clk = ~clk;

  task automatic send_request(input logic k, input logic [7:0] b, input logic seg);
    in_item_t req;
    req.kind        = k;
    req.data_byte   = b;
    req.segment_end = seg;
    if (tx_gaps_on) begin
      while ($urandom_range(99) < 17) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= b;
    s_axis_tlast  <= seg;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(req);
    sent_items++;
  endtask

  task automatic pause_sender();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_max_size(input logic [31:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.max_size = value;
  endtask

  task automatic resync_channel();
    if (sb.phase != PH_SIZE || sb.byte_count != 0)
      send_request(KIND_RESET, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_message(input logic [31:0] len, input int body_n);
    for (int i = 0; i < 4; i++)
      send_request(KIND_DATA, len[8*i +: 8], $urandom_range(7) == 0);
    for (int i = 0; i < body_n; i++)
      send_request(KIND_DATA, 8'($urandom), $urandom_range(7) == 0);
  endtask

  function automatic logic [31:0] pick_length(input logic [31:0] max);
    logic [31:0] cap;
    cap = (max > 32'd300) ? 32'd300 : max;
    if (cap < MIN_MESSAGE_SIZE) return MIN_MESSAGE_SIZE;
    case ($urandom_range(9))
      0: return cap;
      1: return $urandom_range(cap, MIN_MESSAGE_SIZE);
      default: return $urandom_range((cap > 32'd40) ? 32'd40 : cap, MIN_MESSAGE_SIZE);
    endcase
  endfunction

  task automatic send_bad_size();
    logic [31:0] size;
    bit          seg_last;
    if (sb.max_size == 32'hFFFF_FFFF || $urandom_range(2) == 0)
      size = $urandom_range(6, 0);
    else if ($urandom_range(1))
      size = sb.max_size + 32'd1;
    else
      size = $urandom | 32'h8000_0000;
    seg_last = 1'($urandom_range(1));
    for (int i = 0; i < 3; i++)
      send_request(KIND_DATA, size[8*i +: 8], $urandom_range(7) == 0);
    send_request(KIND_DATA, size[31:24], seg_last);
    if (!seg_last) begin
      if ($urandom_range(4) == 0) begin
        send_request(KIND_RESET, 8'($urandom), 1'($urandom));
      end else begin
        repeat ($urandom_range(4)) send_request(KIND_DATA, 8'($urandom), 1'b0);
        send_request(KIND_DATA, 8'($urandom), 1'b1);
      end
    end
  endtask

  task automatic random_sequence();
    int unsigned pick;
    logic [31:0] len;
    pick = $urandom_range(99);
    if (pick < 90) resync_channel();
    if (pick < 65) begin
      len = pick_length(sb.max_size);
      send_message(len, len - 4);
    end else if (pick < 80) begin
      send_bad_size();
    end else if (pick < 90) begin
      len = pick_length(sb.max_size);
      send_message(len, $urandom_range(len - 5, 0));
      send_request(KIND_RESET, 8'($urandom), 1'($urandom));
    end else begin
      repeat ($urandom_range(6, 1))
        send_request(($urandom_range(9) == 0) ? KIND_RESET : KIND_DATA, 8'($urandom),
                     $urandom_range(3) == 0);
    end
  endtask

  initial begin : result_sink
    result_t got;
    int      hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got.status         = status_t'(m_axis_tuser);
        got.out_byte       = m_axis_tdata[7:0];
        got.message_last   = m_axis_tlast;
        got.message_length = m_axis_tdata[39:8];
        sb.check_result(got);
      end
      if (rx_hold_req) begin
        hold_left   = 400;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= rx_gaps_on ? ($urandom_range(99) >= 17) : 1'b1;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [31:0] plan[7];
    int          budget;
    plan = '{MAX_SIZE_RESET, 32'd7, 32'hFFFF_FFFF, 32'd6, 32'd0, 32'd64, 32'd0};
    plan[6] = $urandom_range(2000, 8);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        pause_sender();
        write_max_size(plan[p]);
      end
      tx_gaps_on = (plan[p] != 32'hFFFF_FFFF);
      rx_gaps_on = tx_gaps_on;

      if (p == 0) begin
        // smallest message, size field split across segments
        send_request(KIND_DATA, 8'h07, 1'b0);
        send_request(KIND_DATA, 8'h00, 1'b1);
        send_request(KIND_DATA, 8'h00, 1'b0);
        send_request(KIND_DATA, 8'h00, 1'b0);
        send_request(KIND_DATA, 8'h00, 1'b0);
        send_request(KIND_DATA, 8'hFF, 1'b0);
        send_request(KIND_DATA, 8'hA5, 1'b1);
        // undersized, size field ends its segment
        send_request(KIND_DATA, 8'h06, 1'b0);
        send_request(KIND_DATA, 8'h00, 1'b0);
        send_request(KIND_DATA, 8'h00, 1'b0);
        send_request(KIND_DATA, 8'h00, 1'b1);
        // oversized, drop through segment end
        send_request(KIND_DATA, 8'h01, 1'b0);
        send_request(KIND_DATA, 8'h20, 1'b0);
        send_request(KIND_DATA, 8'h00, 1'b0);
        send_request(KIND_DATA, 8'h00, 1'b0);
        send_request(KIND_DATA, 8'h55, 1'b0);
        send_request(KIND_DATA, 8'hAA, 1'b1);
        // channel reset inside a size field
        send_request(KIND_DATA, 8'h0A, 1'b0);
        send_request(KIND_DATA, 8'h00, 1'b0);
        send_request(KIND_RESET, 8'hFF, 1'b1);
        // channel reset inside a body
        send_message(32'd10, 2);
        send_request(KIND_RESET, 8'h00, 1'b0);
        // hold the sink so the block backs up
        pause_sender();
        rx_hold_req = 1'b1;
        send_message(32'd260, 256);
        pause_sender();
      end
      if (p == 2) begin
        // largest size accepted, then aborted
        resync_channel();
        send_message(32'hFFFF_FFFF, 2);
        send_request(KIND_RESET, 8'h3C, 1'b1);
      end

      budget = sent_items + 135;
      while (sent_items < budget) random_sequence();
    end

    pause_sender();
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
